// ----- hdl/fpadd_pkg.sv -----
// Package for the single-precision adder pipeline.
// Holds shared constants and the stage payload types; no dependencies.
package fpadd_pkg;
	localparam int unsigned EXP_W  = 8;
	localparam int unsigned FRAC_W = 23;
	localparam int unsigned SIG_W  = 24;
	localparam logic [7:0] EXP_MAX = 8'd255;
	localparam logic [31:0] QNAN_WORD = 32'h7FC0_0000;

	typedef struct packed {
		logic        special;
		logic [31:0] special_word;
		logic        sign;
		logic        sub;
		logic [7:0]  rexp;
		logic [23:0] big_m;
		logic [23:0] small_m;
		logic [4:0]  shift;
		logic        shift_zero;
	} align_t;

	typedef struct packed {
		logic        special;
		logic [31:0] special_word;
		logic        sign;
		logic [9:0]  rexp;
		logic [24:0] sum;
		logic        cancel;
	} addsub_t;
endpackage

// ----- hdl/fpadd_unpack.sv -----
// Stage 1: unpack operands, handle special cases, order by magnitude.
// Depends on fpadd_pkg.
module fpadd_unpack (
	input  logic [31:0]            operand_a,
	input  logic [31:0]            operand_b,
	output fpadd_pkg::align_t      res
);
	import fpadd_pkg::*;
	logic [7:0] ea, eb, d;
	logic [23:0] ma, mb;
	logic a_big;
	always_comb begin
		ea = operand_a[30:23];
		eb = operand_b[30:23];
		ma = {1'b1, operand_a[22:0]};
		mb = {1'b1, operand_b[22:0]};
		a_big = (ea > eb) || (ea == eb && ma >= mb);
		d = a_big ? ea - eb : eb - ea;
		res = '0;
		res.sub = operand_a[31] ^ operand_b[31];
		res.sign = a_big ? operand_a[31] : operand_b[31];
		res.rexp = a_big ? ea : eb;
		res.big_m = a_big ? ma : mb;
		res.small_m = a_big ? mb : ma;
		res.shift = d[4:0];
		res.shift_zero = d >= 8'd24;
		if (ea == EXP_MAX || eb == EXP_MAX) begin
			res.special = 1'b1;
			res.special_word = QNAN_WORD;
		end else if (ea == 8'd0 && eb == 8'd0) begin
			res.special = 1'b1;
			res.special_word = {operand_a[31] & operand_b[31], 31'd0};
		end else if (ea == 8'd0) begin
			res.special = 1'b1;
			res.special_word = operand_b;
		end else if (eb == 8'd0) begin
			res.special = 1'b1;
			res.special_word = operand_a;
		end
	end
endmodule

// ----- hdl/fpadd_addsub.sv -----
// Stage 2: align the smaller significand and add or subtract magnitudes.
// Depends on fpadd_pkg.
module fpadd_addsub (
	input  fpadd_pkg::align_t  op,
	output fpadd_pkg::addsub_t res
);
	import fpadd_pkg::*;
	logic [23:0] sm;
	always_comb begin
		sm = op.shift_zero ? 24'd0 : (op.small_m >> op.shift);
		res.special = op.special;
		res.special_word = op.special_word;
		res.sign = op.sign;
		res.rexp = {2'b00, op.rexp};
		res.sum = op.sub ? {1'b0, op.big_m - sm} : {1'b0, op.big_m} + {1'b0, sm};
		res.cancel = op.sub && (op.big_m == sm);
	end
endmodule

// ----- hdl/fpadd_norm.sv -----
// Stage 3: normalize, detect overflow and underflow, pack the result.
// Depends on fpadd_pkg.
module fpadd_norm (
	input  fpadd_pkg::addsub_t op,
	output logic [31:0]        word
);
	import fpadd_pkg::*;
	logic [4:0] lz;
	logic [23:0] m;
	logic [9:0] e;
	always_comb begin
		lz = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (op.sum[i]) begin
				lz = 5'(23 - i);
			end
		end
		if (op.sum[24]) begin
			m = op.sum[24:1];
			e = op.rexp + 10'd1;
		end else begin
			m = op.sum[23:0] << lz;
			e = op.rexp - {5'd0, lz};
		end
		if (op.special) begin
			word = op.special_word;
		end else if (op.cancel) begin
			word = 32'd0;
		end else if (!e[9] && e > 10'd254) begin
			word = {op.sign, EXP_MAX, 23'd0};
		end else if (e[9] || e == 10'd0) begin
			word = {op.sign, 31'd0};
		end else begin
			word = {op.sign, e[7:0], m[22:0]};
		end
	end
endmodule

// ----- hdl/float32_adder_unit.sv -----
// Single-precision floating-point adder, truncating, three pipeline stages.
// Depends on fpadd_pkg, fpadd_unpack, fpadd_addsub and fpadd_norm.
//
// Usage: the input channel (in_valid, in_stall, operand_a, operand_b)
// takes one transaction per cycle while in_stall is low. The output channel
// (out_valid, out_stall, sum_word) delivers one sum per input transaction,
// in order. Stage 1 unpacks and orders operands, stage 2 aligns and adds,
// stage 3 normalizes and packs into the output register.
// An accepted transaction passes the stage 1 and stage 2 registers and then
// reaches the output register, where out_valid shows it; throughput is one
// transaction per cycle while in_stall is low. A stage holds its data
// only while every stage after it is full and the receiver stalls, while an
// empty stage still fills, so bubbles are squeezed out. in_stall is high
// exactly when the first stage is full and cannot advance.
// Reset clears all valid bits; the pipeline starts empty.
module float32_adder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] operand_a,
	input  logic [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] sum_word
);
	import fpadd_pkg::*;
	align_t  al_c, al_s1;
	addsub_t as_c, as_s2;
	logic [31:0] w_c, w_s3;
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	fpadd_unpack u_unpack (.operand_a(operand_a), .operand_b(operand_b), .res(al_c));
	fpadd_addsub u_addsub (.op(al_s1), .res(as_c));
	fpadd_norm   u_norm   (.op(as_s2), .word(w_c));

	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign out_valid = v_s3;
	assign sum_word = w_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) al_s1 <= al_c;
		if (en2) as_s2 <= as_c;
		if (en3) w_s3 <= w_c;
	end
endmodule

// ----- sim/float32_adder_unit_tb.sv -----
// Testbench for float32_adder_unit: drives operand pairs with random gaps and
// checks every sum against a truncating single-precision adder model.
// Depends on fpadd_pkg and the float32_adder_unit RTL.
class sum_scoreboard;
	logic [31:0] pending_sums[$];
	int errors;

	function new();
		errors = 0;
	endfunction

	static function logic [31:0] truncated_sum(logic [31:0] a, logic [31:0] b);
		logic sa, sb, big_s, small_s, rsign;
		logic [7:0] ea, eb;
		logic [31:0] ma, mb, big_m, small_m, d, total;
		int rexp;
		sa = a[31];
		sb = b[31];
		ea = a[30:23];
		eb = b[30:23];
		if (ea == fpadd_pkg::EXP_MAX || eb == fpadd_pkg::EXP_MAX)
			return fpadd_pkg::QNAN_WORD;
		if (ea == 8'd0 && eb == 8'd0)
			return {sa & sb, 31'd0};
		if (ea == 8'd0)
			return b;
		if (eb == 8'd0)
			return a;
		ma = {8'd0, 1'b1, a[22:0]};
		mb = {8'd0, 1'b1, b[22:0]};
		if (ea > eb || (ea == eb && ma >= mb)) begin
			big_m = ma; big_s = sa; small_m = mb; small_s = sb;
			d = ea - eb; rexp = ea;
		end else begin
			big_m = mb; big_s = sb; small_m = ma; small_s = sa;
			d = eb - ea; rexp = eb;
		end
		small_m = (d >= 24) ? 32'd0 : (small_m >> d);
		rsign = big_s;
		if (big_s == small_s) begin
			total = big_m + small_m;
			if (total >= 32'd16777216) begin
				total = total >> 1;
				rexp++;
			end
		end else begin
			total = big_m - small_m;
			if (total == 0)
				return 32'd0;
			while (total < 32'd8388608) begin
				total = total << 1;
				rexp--;
			end
		end
		if (rexp > 254)
			return {rsign, 8'hFF, 23'd0};
		if (rexp < 1)
			return {rsign, 31'd0};
		return {rsign, rexp[7:0], total[22:0]};
	endfunction

	function void note_operands(logic [31:0] a, logic [31:0] b);
		pending_sums.push_back(truncated_sum(a, b));
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_sum(logic [31:0] got);
		logic [31:0] want;
		if (pending_sums.size() == 0) begin
			report($sformatf("unexpected sum %h", got));
			return;
		end
		want = pending_sums.pop_front();
		if (got !== want)
			report($sformatf("sum_word %h, expected %h", got, want));
	endtask
endclass

module float32_adder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [31:0] operand_a = 32'd0;
	logic [31:0] operand_b = 32'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [31:0] sum_word;

	sum_scoreboard board = new();
	int cycle_count = 0;
	bit hold_receiver = 1'b0;
	bit stim_done = 1'b0;

	float32_adder_unit uut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0)
			return $urandom_range(1, 3);
		return 0;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_sum(sum_word);
	end

	initial begin
		int idle;
		idle = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_receiver)
				out_stall <= 1'b1;
			else if (idle > 0) begin
				idle--;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 3) == 0) begin
				idle = gap_len();
				out_stall <= (idle > 0);
			end else
				out_stall <= 1'b0;
		end
	end

	task automatic send_pair(logic [31:0] a, logic [31:0] b, bit gaps);
		int idle;
		idle = gaps ? gap_len() : 0;
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		operand_a <= a;
		operand_b <= b;
		do @(posedge clk); while (in_stall);
		board.note_operands(a, b);
	endtask

	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom();
		case ($urandom_range(0, 9))
			0: w[30:23] = 8'd0;
			1: w[30:23] = 8'd255;
			2: w[30:23] = 8'($urandom_range(250, 254));
			3: w[30:23] = 8'($urandom_range(1, 4));
			default: ;
		endcase
		return w;
	endfunction

	task automatic random_pair();
		logic [31:0] a, b;
		a = random_word();
		b = random_word();
		case ($urandom_range(0, 4))
			0: b[30:23] = 8'(int'(a[30:23]) + int'($urandom_range(0, 30)) - 15);
			1: b = {~a[31], a[30:0]};
			2: b = {~a[31], a[30:23], a[22:0] ^ (23'd1 << $urandom_range(0, 22))};
			default: ;
		endcase
		send_pair(a, b, 1'b1);
	endtask

	initial begin
		logic [31:0] directed[$];
		int k;
		directed = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h3F80_0000,
			32'hBF80_0000, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000,
			32'h8080_0001, 32'h4B80_0000, 32'h3380_0000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (k = 0; k < directed.size(); k++)
			send_pair(directed[k], directed[(k * 7 + 3) % directed.size()], 1'b0);
		send_pair(32'h8000_0000, 32'h8000_0000, 1'b0);
		send_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b0);
		send_pair(32'h0080_0001, 32'h8080_0000, 1'b0);
		send_pair(32'h3F80_0000, 32'hBF80_0000, 1'b0);
		send_pair(32'h4B80_0000, 32'h3F80_0000, 1'b0);
		send_pair(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
		send_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF, 1'b0);
		for (k = 0; k < 700; k++)
			random_pair();
		hold_receiver = 1'b1;
		fork
			begin
				repeat (60) @(posedge clk);
				hold_receiver = 1'b0;
			end
			for (k = 0; k < 20; k++)
				send_pair(random_word(), random_word(), 1'b0);
		join
		go_idle();
		wait (board.pending_sums.size() == 0);
		@(posedge clk);
		for (k = 0; k < 880; k++)
			random_pair();
		go_idle();
		stim_done = 1'b1;
	end

	initial begin
		wait (stim_done);
		wait (board.pending_sums.size() == 0);
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending_sums.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ----- filelist.f -----
hdl/fpadd_pkg.sv
hdl/fpadd_unpack.sv
hdl/fpadd_addsub.sv
hdl/fpadd_norm.sv
hdl/float32_adder_unit.sv
sim/float32_adder_unit_tb.sv
